@@ rtl/syn_ack_timing_drop_table_defines.svh @@
// ----------------------------------------------------------------------------
// SYN / SYN-ACK timing drop table: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SYN_ACK_TIMING_DROP_TABLE_DEFINES_SVH
`define SYN_ACK_TIMING_DROP_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define SATDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("satdt assertion failed");

// implication checked at every clock edge outside reset
`define SATDT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("satdt implication failed");

`else

`define SATDT_ASSERT(label, clk, rst, prop)
`define SATDT_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/satdt_pkg.sv @@
// ----------------------------------------------------------------------------
// satdt_pkg
// Types and constants shared by the SYN / SYN-ACK timing drop table.
// ----------------------------------------------------------------------------
package satdt_pkg;

   // item function codes
   localparam logic [1:0] FUNC_PASS     = 2'd0;
   localparam logic [1:0] FUNC_REGISTER = 2'd1;
   localparam logic [1:0] FUNC_CHECK    = 2'd2;

   // reset value of the speed limit in ms
   localparam logic [31:0] SPEED_LIMIT_RESET = 32'd150;

   // one pending syn
   typedef struct packed {
      logic [31:0] remote_addr;
      logic [15:0] peer_port;
      logic [15:0] host_port;
      logic [31:0] time_ms;
   } entry_type;

   // verdict of the compare unit on one entry
   typedef struct packed {
      logic expired;
      logic match;
   } cmp_result_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

@@ rtl/satdt_entry_ram.sv @@
// ----------------------------------------------------------------------------
// satdt_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module satdt_entry_ram #(
   parameter int TABLE_DEPTH = 16,
   parameter int ADDR_W      = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  satdt_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output satdt_pkg::entry_type  rd_data
);
   import satdt_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/satdt_age_cmp.sv @@
// ----------------------------------------------------------------------------
// satdt_age_cmp
// Shared compare unit: wrapping age test and three-key match on one entry.
// ----------------------------------------------------------------------------
module satdt_age_cmp (
   input  satdt_pkg::entry_type       entry,
   input  logic [31:0]                key_addr,
   input  logic [15:0]                key_rport,
   input  logic [15:0]                key_lport,
   input  logic [31:0]                now_ms,
   input  logic [31:0]                limit_ms,
   output satdt_pkg::cmp_result_type  result
);
   import satdt_pkg::*;

   logic [31:0] age;

   // age modulo 2^32, then limit compare
   assign age            = now_ms - entry.time_ms;
   assign result.expired = (age > limit_ms);

   // all three keys must agree
   assign result.match = (entry.remote_addr == key_addr) &&
                         (entry.peer_port == key_rport) &&
                         (entry.host_port == key_lport);

endmodule

@@ rtl/syn_ack_timing_drop_table.sv @@
// ----------------------------------------------------------------------------
// syn_ack_timing_drop_table
// FIFO table of outgoing SYNs; flags SYN-ACKs that arrive too quickly.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive req_* and raise start; the word is taken at an edge where
//   start is high and busy is low. req_func 1 appends a SYN entry (the oldest
//   one is overwritten when the table is full), 2 checks a SYN-ACK, anything
//   else passes.
//   Output: exactly one result word per input word, shown on rsp_* for one
//   cycle with rsp_valid high. The receiver cannot stall; it must take it.
//   Pass and register words answer in the cycle after acceptance and
//   busy stays low, so one such word can be taken every cycle.
//   Check words walk the held entries through one compare unit, one entry
//   per cycle over the single read port of the entry memory; busy is high
//   from acceptance until the answer shows. Expired entries are dropped and
//   survivors are packed toward the head in the same pass.
//   Configuration: csr_wdata sets the speed limit in ms when csr_valid and
//   csr_ready are high; csr_ready is high while the block is idle.
//   Reset: synchronous; the table empties, the speed limit returns to 150.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "syn_ack_timing_drop_table_defines.svh"

module syn_ack_timing_drop_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_func,
   input  logic [31:0]                          req_remote_addr,
   input  logic [15:0]                          req_peer_port,
   input  logic [15:0]                          req_host_port,
   input  logic [31:0]                          req_now_ms,
   // response channel
   output logic                                 rsp_valid,
   output logic                                 rsp_drop,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     rsp_pending_count,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [31:0]                          csr_wdata
);
   import satdt_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   // head plus offset, wrapped into the table
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(TABLE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(TABLE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // control state
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [31:0]        limit_ff, limit_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   ev_idx_ff, ev_idx_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic               pend_ff, pend_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [31:0]        key_addr_ff, key_addr_in;
   logic [15:0]        key_rport_ff, key_rport_in;
   logic [15:0]        key_lport_ff, key_lport_in;
   logic [31:0]        now_ff, now_in;
   logic               rsp_drop_ff, rsp_drop_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // memory and compare unit hookup
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   entry_type          rd_data;
   cmp_result_type     cmp;

   logic               accept;
   logic               issue;

   satdt_entry_ram #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   satdt_age_cmp u_cmp (
      .entry     (rd_data),
      .key_addr  (key_addr_ff),
      .key_rport (key_rport_ff),
      .key_lport (key_lport_ff),
      .now_ms    (now_ff),
      .limit_ms  (limit_ff),
      .result    (cmp)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign issue     = (rd_idx_ff != count_ff);

   // sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= SPEED_LIMIT_RESET;
         rd_idx_ff    <= '0;
         ev_idx_ff    <= '0;
         kept_ff      <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rd_idx_ff    <= rd_idx_in;
         ev_idx_ff    <= ev_idx_in;
         kept_ff      <= kept_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_addr_ff  <= key_addr_in;
      key_rport_ff <= key_rport_in;
      key_lport_ff <= key_lport_in;
      now_ff       <= now_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_count_ff <= rsp_count_in;
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      rd_idx_in    = rd_idx_ff;
      ev_idx_in    = ev_idx_ff;
      kept_in      = kept_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      key_addr_in  = key_addr_ff;
      key_rport_in = key_rport_ff;
      key_lport_in = key_lport_ff;
      now_in       = now_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, count_ff);
      wr_data      = '{remote_addr: req_remote_addr, peer_port: req_peer_port,
                       host_port: req_host_port, time_ms: req_now_ms};
      rd_addr      = slot_of(head_ff, rd_idx_ff);

      // configuration write
      if (csr_valid && csr_ready) begin
         limit_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_addr_in  = req_remote_addr;
               key_rport_in = req_peer_port;
               key_lport_in = req_host_port;
               now_in       = req_now_ms;
               rsp_valid_in = 1'b1;
               rsp_drop_in  = 1'b0;
               rsp_count_in = count_ff;
               case (req_func)
                  FUNC_REGISTER: begin
                     // append at the tail, overwrite the oldest when full
                     wr_en = 1'b1;
                     if (count_ff == DEPTH_CNT) begin
                        head_in = slot_of(head_ff, ONE_CNT);
                     end else begin
                        count_in     = count_ff + ONE_CNT;
                        rsp_count_in = count_ff + ONE_CNT;
                     end
                  end
                  FUNC_CHECK: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                     rd_idx_in    = '0;
                     ev_idx_in    = '0;
                     kept_in      = '0;
                     pend_in      = 1'b0;
                     found_in     = 1'b0;
                  end
                  FUNC_PASS: begin
                     rsp_count_in = count_ff;
                  end
                  default: begin
                     rsp_count_in = count_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue the next read
            pend_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + ONE_CNT;
            end
            // evaluate the word read last cycle, pack survivors to the head
            wr_data = rd_data;
            wr_addr = slot_of(head_ff, kept_ff);
            if (pend_ff) begin
               ev_idx_in = ev_idx_ff + ONE_CNT;
               if (!cmp.expired) begin
                  found_in = found_ff | cmp.match;
                  wr_en    = (kept_ff != ev_idx_ff);
                  kept_in  = kept_ff + ONE_CNT;
               end
            end
            // finish when nothing is in flight
            if (!issue && !pend_ff) begin
               state_in     = ST_IDLE;
               count_in     = kept_ff;
               rsp_valid_in = 1'b1;
               rsp_drop_in  = found_ff;
               rsp_count_in = kept_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drop          = rsp_drop_ff;
   assign rsp_pending_count = rsp_count_ff;

   // checks
   `SATDT_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_CNT)
   `SATDT_ASSERT_IMPL(a_kept_bound, clock, reset, state_ff == ST_SCAN, kept_ff <= ev_idx_ff)
   `SATDT_ASSERT_IMPL(a_done_strobe, clock, reset, $fell(busy), rsp_valid)
   `SATDT_ASSERT_IMPL(a_drop_from_check, clock, reset, rsp_valid && rsp_drop, $past(busy))

endmodule

@@ tb/sv/syn_ack_timing_drop_table_tb.sv @@
// ----------------------------------------------------------------------------
// syn_ack_timing_drop_table_tb
// Self-checking testbench for the SYN / SYN-ACK timing drop table. A shadow
// copy of the pending-SYN table predicts drop and pending count for every
// accepted word. Directed words cover empty-table checks, unused function
// codes, the age boundary across tick wrap, key near misses and table
// overflow. Random traffic then runs under several speed limits, with
// random sender gaps.
// ----------------------------------------------------------------------------
module syn_ack_timing_drop_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import satdt_pkg::*;

   localparam int         DEPTH       = 16;
   localparam int         CNT_W       = $clog2(DEPTH + 1);
   localparam int         CYCLE_LIMIT = 400000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic             drop;
      logic [CNT_W-1:0] pending;
   } verdict_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] rport;
      logic [15:0] lport;
   } syn_key_type;

   // dut ports
   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_func;
   logic [31:0]      req_remote_addr;
   logic [15:0]      req_peer_port;
   logic [15:0]      req_host_port;
   logic [31:0]      req_now_ms;
   logic             rsp_valid;
   logic             rsp_drop;
   logic [CNT_W-1:0] rsp_pending_count;
   logic             csr_valid;
   logic             csr_ready;
   logic [31:0]      csr_wdata;

   // shadow table state
   entry_type        shadow_slots [DEPTH];
   int unsigned      shadow_head  = 0;
   int unsigned      shadow_count = 0;
   logic [31:0]      shadow_limit = SPEED_LIMIT_RESET;

   verdict_type      verdict_q [$];
   syn_key_type      sent_keys [$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               gaps_on        = 1'b1;

   syn_ack_timing_drop_table #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_remote_addr   (req_remote_addr),
      .req_peer_port     (req_peer_port),
      .req_host_port     (req_host_port),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_drop          (rsp_drop),
      .rsp_pending_count (rsp_pending_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one mismatch line, counted
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // predict drop and pending count for one word, updating the shadow table
   function automatic verdict_type track_syn_table(input logic [1:0] func,
                                                   input syn_key_type key,
                                                   input logic [31:0] now);
      verdict_type v;
      entry_type   src;
      logic [31:0] age;
      int unsigned kept;
      v.drop = 1'b0;
      if (func == FUNC_REGISTER) begin
         shadow_slots[(shadow_head + shadow_count) % DEPTH] =
            '{key.addr, key.rport, key.lport, now};
         if (shadow_count == DEPTH)
            shadow_head = (shadow_head + 1) % DEPTH;
         else
            shadow_count++;
      end else if (func == FUNC_CHECK) begin
         kept = 0;
         for (int unsigned i = 0; i < shadow_count; i++) begin
            src = shadow_slots[(shadow_head + i) % DEPTH];
            age = now - src.time_ms;
            // young entries survive, packed toward the head
            if (age <= shadow_limit) begin
               if (src.remote_addr == key.addr && src.peer_port == key.rport &&
                   src.host_port == key.lport)
                  v.drop = 1'b1;
               shadow_slots[(shadow_head + kept) % DEPTH] = src;
               kept++;
            end
         end
         shadow_count = kept;
      end
      v.pending = CNT_W'(shadow_count);
      return v;
   endfunction

   // response checker and predictor, one process so nothing races
   always @(posedge clock) begin : rsp_check
      verdict_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("response word with nothing outstanding");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_drop !== want.drop)
                  report_mismatch($sformatf("drop %b, expected %b", rsp_drop, want.drop));
               if (rsp_pending_count !== want.pending)
                  report_mismatch($sformatf("pending_count %0d, expected %0d",
                                            rsp_pending_count, want.pending));
            end
         end
         if (csr_valid && csr_ready)
            shadow_limit = csr_wdata;
         if (start && !busy)
            verdict_q.push_back(track_syn_table(req_func,
               '{req_remote_addr, req_peer_port, req_host_port}, req_now_ms));
      end
   end

   // send one request word, with an optional random gap first
   task automatic send_word(input logic [1:0] func, input syn_key_type key,
                            input logic [31:0] now);
      int gap;
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start           <= 1'b1;
      req_func        <= func;
      req_remote_addr <= key.addr;
      req_peer_port   <= key.rport;
      req_host_port   <= key.lport;
      req_now_ms      <= now;
      do @(posedge clock); while (busy);
      if (func == FUNC_REGISTER) begin
         sent_keys.push_back(key);
         if (sent_keys.size() > 20)
            void'(sent_keys.pop_front());
      end
   endtask

   // stop sending and wait for every outstanding word
   task automatic drain_words();
      @(negedge clock);
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write the speed limit while idle
   task automatic write_speed_limit(input logic [31:0] value);
      drain_words();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // empty table check and words that change nothing
   task automatic test_empty_and_pass();
      send_word(FUNC_CHECK, '1, '1);
      send_word(FUNC_PASS, '1, '1);
      send_word(FUNC_PASS, '0, '0);
      send_word(FUNC_UNUSED, '1, '1);
   endtask

   // age exactly at the limit is kept, one past it expires, across tick wrap
   task automatic test_age_boundary();
      logic [31:0] t0;
      t0 = 32'hFFFF_FFC0;
      send_word(FUNC_REGISTER, '1, t0);
      send_word(FUNC_REGISTER, '0, t0 + 32'd100);
      send_word(FUNC_CHECK, '1, t0 + SPEED_LIMIT_RESET);
      send_word(FUNC_CHECK, '1, t0 + SPEED_LIMIT_RESET + 32'd1);
   endtask

   // all three keys must match
   task automatic test_key_match();
      logic [31:0] t1;
      t1 = 32'hFFFF_FFC0 + 32'd200;
      send_word(FUNC_CHECK, '{32'h0000_0001, 16'h0000, 16'h0000}, t1);
      send_word(FUNC_CHECK, '{32'h0000_0000, 16'h8000, 16'h0000}, t1);
      send_word(FUNC_CHECK, '{32'h0000_0000, 16'h0000, 16'h0001}, t1);
      send_word(FUNC_CHECK, '0, t1);
   endtask

   // fill past capacity, oldest entries get overwritten
   task automatic test_full_table();
      write_speed_limit('1);
      for (int i = 0; i < DEPTH; i++)
         send_word(FUNC_REGISTER, '{32'hA000_0000 + i, 16'(i), 16'(1000 + i)},
                   32'd300 + i);
      send_word(FUNC_CHECK, '0, 32'd400);
      send_word(FUNC_CHECK, '{32'hA000_0000, 16'd0, 16'd1000}, 32'd400);
      send_word(FUNC_REGISTER, '{32'hB000_0000, 16'hFFFF, 16'hFFFF}, 32'd401);
      send_word(FUNC_CHECK, '{32'hA000_0000, 16'd0, 16'd1000}, 32'd402);
   endtask

   // random traffic under one speed limit
   task automatic test_random_traffic(input logic [31:0] limit, input int n_words);
      logic [31:0] tick;
      logic [31:0] span;
      syn_key_type key;
      int          pick;
      int          field;
      write_speed_limit(limit);
      // start some phases just below the tick wrap
      tick = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 3000);
      span = (limit > 32'd1000) ? 32'd1000 : limit;
      for (int k = 0; k < n_words; k++) begin
         if (k % 40 == 0)
            gaps_on = $urandom_range(0, 2) != 0;
         // time mostly creeps, sometimes jumps past the limit
         if ($urandom_range(0, 9) == 0)
            tick += $urandom_range(0, 2 * span + 2);
         else
            tick += $urandom_range(0, span / 4 + 1);
         key  = {$urandom(), 16'($urandom()), 16'($urandom())};
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // new syn, sometimes a repeat of a recent one
            if (sent_keys.size() != 0 && $urandom_range(0, 3) == 0)
               key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
            send_word(FUNC_REGISTER, key, tick);
         end else if (pick < 87) begin
            // syn-ack, mostly for a recent syn, some near misses
            if (sent_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
               key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
               if ($urandom_range(0, 4) == 0) begin
                  field = $urandom_range(0, 2);
                  if (field == 0)
                     key.addr[$urandom_range(0, 31)] ^= 1'b1;
                  else if (field == 1)
                     key.rport[$urandom_range(0, 15)] ^= 1'b1;
                  else
                     key.lport[$urandom_range(0, 15)] ^= 1'b1;
               end
            end
            send_word(FUNC_CHECK, key, tick);
         end else if (pick < 95) begin
            send_word($urandom_range(0, 1) ? FUNC_PASS : FUNC_UNUSED, key, $urandom());
         end else begin
            // out of order tick, expires entries away from the head
            send_word($urandom_range(0, 1) ? FUNC_REGISTER : FUNC_CHECK, key, $urandom());
         end
      end
   endtask

   // main sequence
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = FUNC_PASS;
      req_remote_addr = '0;
      req_peer_port   = '0;
      req_host_port   = '0;
      req_now_ms      = '0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_pass();
      test_age_boundary();
      test_key_match();
      test_full_table();
      test_random_traffic(SPEED_LIMIT_RESET, 200);
      test_random_traffic(32'd0, 150);
      test_random_traffic(32'hFFFF_FFFF, 150);
      test_random_traffic(32'd1, 150);
      test_random_traffic(32'd1000, 200);
      test_random_traffic(32'd20 + $urandom_range(0, 400), 250);

      drain_words();
      repeat (20) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived", verdict_q.size()));
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
